// File: hdl/assert_macros.svh
// Assertion helpers shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define STZ_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define STZ_ASSERT_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// File: hdl/stz_pkg.sv
package stz_pkg;

   // Scanner modes
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_INT,
      MODE_DEC,
      MODE_EQ,
      MODE_STR,
      MODE_HALT
   } mode_type;

   // Token kinds as they leave the block
   typedef enum logic [3:0] {
      KIND_PLUS,
      KIND_MINUS,
      KIND_EQEQ,
      KIND_EQ,
      KIND_COLON,
      KIND_LPAREN,
      KIND_RPAREN,
      KIND_VAR,
      KIND_FUN,
      KIND_IDENT,
      KIND_INT,
      KIND_DEC,
      KIND_STRING,
      KIND_ERROR
   } kind_type;

   localparam int unsigned LINE_W    = 16;
   localparam int unsigned TOKENS_MAX = 3;

   typedef struct packed {
      kind_type           kind;
      logic [LINE_W-1:0]  start;
      logic [LINE_W-1:0]  length;
      logic [LINE_W-1:0]  line;
   } lexeme_type;

   // All tokens caused by one source byte; count is 1..3 when queued
   typedef struct packed {
      logic [1:0]                  count;
      lexeme_type [TOKENS_MAX-1:0] tok;
   } bundle_type;

   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;

   localparam logic [23:0] KW_VAR = "var";
   localparam logic [23:0] KW_FUN = "fun";

endpackage

// File: hdl/stz_front.sv
module stz_front #(
   parameter int unsigned MAX_SOURCE_BYTES = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          text_byte,
   input  logic                source_end,
   input  logic                cfg_we,
   input  logic [15:0]         cfg_data,
   output logic                push,
   output stz_pkg::bundle_type bundle,
   output stz_pkg::mode_type   mode
);

   localparam int unsigned PW = $clog2(MAX_SOURCE_BYTES + 1);
   localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_SOURCE_BYTES);

   typedef struct packed {
      stz_pkg::mode_type mode;
      logic [PW-1:0]     pos;
      logic [PW-1:0]     tstart;
      logic [15:0]       line;
      logic [2:0]        wlen;
      logic [1:0]        kmatch;
   } state_type;

   typedef struct packed {
      state_type           st;
      stz_pkg::bundle_type bun;
   } scan_type;

   typedef struct packed {
      logic               valid;
      stz_pkg::lexeme_type tok;
   } pend_type;

   state_type   state_ff, state_in;
   logic [15:0] first_line_ff, first_line_in;
   scan_type    scan;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic [7:0] kw_byte(logic [23:0] kw, logic [1:0] i);
      logic [7:0] b;
      unique case (i)
         2'd0:    b = kw[23:16];
         2'd1:    b = kw[15:8];
         default: b = kw[7:0];
      endcase
      return b;
   endfunction

   function automatic stz_pkg::lexeme_type mk_tok(stz_pkg::kind_type k, logic [PW-1:0] s,
                                                  logic [PW-1:0] len, logic [15:0] line);
      stz_pkg::lexeme_type t;
      t.kind   = k;
      t.start  = 16'(s);
      t.length = 16'(len);
      t.line   = line;
      return t;
   endfunction

   function automatic stz_pkg::bundle_type add_tok(stz_pkg::bundle_type b,
                                                   stz_pkg::lexeme_type t);
      stz_pkg::bundle_type o;
      o = b;
      o.tok[b.count] = t;
      o.count = b.count + 2'd1;
      return o;
   endfunction

   // Token left open by the current mode, ending just before pos
   function automatic pend_type pending(state_type s);
      pend_type      p;
      logic [PW-1:0] len;
      len = s.pos - s.tstart;
      p.valid = 1'b1;
      p.tok = mk_tok(stz_pkg::KIND_IDENT, s.tstart, len, s.line);
      unique case (s.mode)
         stz_pkg::MODE_WORD: begin
            if (s.wlen == 3'd3 && s.kmatch[0]) begin
               p.tok = mk_tok(stz_pkg::KIND_VAR, s.tstart, '0, s.line);
            end else if (s.wlen == 3'd3 && s.kmatch[1]) begin
               p.tok = mk_tok(stz_pkg::KIND_FUN, s.tstart, '0, s.line);
            end
         end
         stz_pkg::MODE_INT: p.tok = mk_tok(stz_pkg::KIND_INT, s.tstart, len, s.line);
         stz_pkg::MODE_DEC: p.tok = mk_tok(stz_pkg::KIND_DEC, s.tstart, len, s.line);
         stz_pkg::MODE_EQ:  p.tok = mk_tok(stz_pkg::KIND_EQ, s.tstart, '0, s.line);
         stz_pkg::MODE_STR: p.tok = mk_tok(stz_pkg::KIND_ERROR, s.tstart, '0, s.line);
         default:           p.valid = 1'b0;
      endcase
      return p;
   endfunction

   function automatic scan_type scan_step(state_type s_in, logic [7:0] c, logic last,
                                          logic [15:0] fl);
      scan_type      r;
      state_type     s;
      pend_type      p;
      logic          fresh;
      logic [PW-1:0] pos;
      s = s_in;
      r.bun = '0;
      fresh = 1'b1;
      pos = s.pos;
      if (s.mode != stz_pkg::MODE_HALT) begin
         if (pos == POS_LIMIT) begin
            r.bun = add_tok(r.bun, mk_tok(stz_pkg::KIND_ERROR, pos, '0, s.line));
            s.mode = stz_pkg::MODE_HALT;
         end else begin
            // continue or close the open token
            unique case (s.mode)
               stz_pkg::MODE_WORD: begin
                  if (is_letter(c) || is_digit(c)) begin
                     fresh = 1'b0;
                     if (s.wlen < 3'd3) begin
                        if (c != kw_byte(stz_pkg::KW_VAR, s.wlen[1:0])) s.kmatch[0] = 1'b0;
                        if (c != kw_byte(stz_pkg::KW_FUN, s.wlen[1:0])) s.kmatch[1] = 1'b0;
                     end
                     if (s.wlen != 3'd7) s.wlen = s.wlen + 3'd1;
                  end
               end
               stz_pkg::MODE_INT: begin
                  if (is_digit(c)) begin
                     fresh = 1'b0;
                  end else if (c == stz_pkg::CH_DOT) begin
                     fresh = 1'b0;
                     s.mode = stz_pkg::MODE_DEC;
                  end
               end
               stz_pkg::MODE_DEC: fresh = !is_digit(c);
               stz_pkg::MODE_EQ: begin
                  if (c == stz_pkg::CH_EQUAL) begin
                     fresh = 1'b0;
                     r.bun = add_tok(r.bun, mk_tok(stz_pkg::KIND_EQEQ, s.tstart, '0, s.line));
                     s.mode = stz_pkg::MODE_IDLE;
                  end
               end
               stz_pkg::MODE_STR: begin
                  fresh = 1'b0;
                  if (c == stz_pkg::CH_QUOTE) begin
                     r.bun = add_tok(r.bun,
                                     mk_tok(stz_pkg::KIND_STRING, s.tstart, pos - s.tstart,
                                            s.line));
                     s.mode = stz_pkg::MODE_IDLE;
                  end
               end
               default: ;
            endcase
            if (fresh) begin
               p = pending(s);
               if (p.valid) r.bun = add_tok(r.bun, p.tok);
               s.mode = stz_pkg::MODE_IDLE;
               unique case (c)
                  stz_pkg::CH_NL: s.line = s.line + 16'd1;
                  stz_pkg::CH_SPACE, stz_pkg::CH_TAB, stz_pkg::CH_CR,
                  stz_pkg::CH_VT, stz_pkg::CH_FF: ;
                  stz_pkg::CH_PLUS:
                     r.bun = add_tok(r.bun, mk_tok(stz_pkg::KIND_PLUS, pos, '0, s.line));
                  stz_pkg::CH_MINUS:
                     r.bun = add_tok(r.bun, mk_tok(stz_pkg::KIND_MINUS, pos, '0, s.line));
                  stz_pkg::CH_COLON:
                     r.bun = add_tok(r.bun, mk_tok(stz_pkg::KIND_COLON, pos, '0, s.line));
                  stz_pkg::CH_LPAREN:
                     r.bun = add_tok(r.bun, mk_tok(stz_pkg::KIND_LPAREN, pos, '0, s.line));
                  stz_pkg::CH_RPAREN:
                     r.bun = add_tok(r.bun, mk_tok(stz_pkg::KIND_RPAREN, pos, '0, s.line));
                  stz_pkg::CH_EQUAL: begin
                     s.mode = stz_pkg::MODE_EQ;
                     s.tstart = pos;
                  end
                  stz_pkg::CH_QUOTE: begin
                     s.mode = stz_pkg::MODE_STR;
                     s.tstart = pos + PW'(1);
                  end
                  default: begin
                     if (is_digit(c)) begin
                        s.mode = stz_pkg::MODE_INT;
                        s.tstart = pos;
                     end else if (is_letter(c)) begin
                        s.mode = stz_pkg::MODE_WORD;
                        s.tstart = pos;
                        s.wlen = 3'd1;
                        s.kmatch = {c == "f", c == "v"};
                     end else begin
                        r.bun = add_tok(r.bun, mk_tok(stz_pkg::KIND_ERROR, pos, PW'(1), s.line));
                        s.mode = stz_pkg::MODE_HALT;
                     end
                  end
               endcase
            end
            s.pos = pos + PW'(1);
         end
      end
      // end of source: flush, then start over
      if (last) begin
         p = pending(s);
         if (p.valid) r.bun = add_tok(r.bun, p.tok);
         s.mode = stz_pkg::MODE_IDLE;
         s.pos = '0;
         s.tstart = '0;
         s.line = fl;
         s.wlen = '0;
         s.kmatch = 2'b11;
      end
      r.st = s;
      return r;
   endfunction

   assign scan = scan_step(state_ff, text_byte, source_end, first_line_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      first_line_in = first_line_ff;
      if (take) begin
         state_in = scan.st;
      end else if (cfg_we && state_ff.pos == '0 && state_ff.mode == stz_pkg::MODE_IDLE) begin
         state_in.line = cfg_data;
      end
      if (cfg_we) first_line_in = cfg_data;
   end

   // outputs
   always_comb begin
      push = take && (scan.bun.count != 2'd0);
      bundle = scan.bun;
      mode = state_ff.mode;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode   <= stz_pkg::MODE_IDLE;
         state_ff.pos    <= '0;
         state_ff.tstart <= '0;
         state_ff.line   <= 16'd1;
         state_ff.wlen   <= '0;
         state_ff.kmatch <= 2'b11;
         first_line_ff   <= 16'd1;
      end else begin
         state_ff      <= state_in;
         first_line_ff <= first_line_in;
      end
   end

endmodule

// File: hdl/stz_queue.sv
module stz_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             not_empty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wptr_ff, wptr_in;
   logic [AW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      count_in = count_ff;
      if (push) wptr_in = (wptr_ff == LAST_SLOT) ? '0 : wptr_ff + AW'(1);
      if (pop)  rptr_in = (rptr_ff == LAST_SLOT) ? '0 : rptr_ff + AW'(1);
      if (push && !pop) count_in = count_ff + CW'(1);
      if (pop && !push) count_in = count_ff - CW'(1);
   end

   assign rdata = slot_ff[rptr_ff];
   assign full = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: hdl/stz_back.sv
module stz_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  stz_pkg::bundle_type q_data,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [47:0]         rsp_tdata,   // lexeme_start, lexeme_length, line_number
   output logic [3:0]          rsp_tuser,   // token_kind
   output logic                rsp_tlast    // run_last
);

   stz_pkg::bundle_type bun_ff, bun_in;
   logic [1:0]          idx_ff, idx_in;
   logic                have_ff, have_in;
   logic                last_tok;
   logic                done;
   stz_pkg::lexeme_type tok;

   assign last_tok = (idx_ff == bun_ff.count - 2'd1);
   assign done = !have_ff || (rsp_tready && last_tok);
   assign q_pop = done && q_valid;

   always_comb begin
      bun_in = bun_ff;
      idx_in = idx_ff;
      have_in = have_ff;
      if (q_pop) begin
         bun_in = q_data;
         idx_in = '0;
         have_in = 1'b1;
      end else if (done) begin
         have_in = 1'b0;
      end else if (rsp_tready) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   assign tok = bun_ff.tok[idx_ff];
   assign rsp_tvalid = have_ff;
   assign rsp_tlast = last_tok;
   assign rsp_tuser = tok.kind;
   assign rsp_tdata = {tok.line, tok.length, tok.start};

   always_ff @(posedge clock) begin
      bun_ff <= bun_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         have_ff <= have_in;
         idx_ff  <= idx_in;
      end
   end

endmodule

// File: hdl/source_tokenizer_top.sv
// Channel  | Direction | Word contents
// ---------+-----------+--------------------------------------------------------
// req_     | in        | tdata[7:0] text_byte, tlast source_end
// rsp_     | out       | tuser[3:0] token_kind, tdata start/length/line, tlast run_last
// csr_     | in        | data[15:0] first_line, one register, no address
//
// One byte is taken per cycle while req_tready is high; the scanner resolves it in that cycle.
// Its tokens (up to 3) leave one per cycle while rsp_tready is high.
// The serializer sets the result rate: it puts a byte's tokens on the result port one by one.
// QUEUE_DEPTH bundles plus one in the serializer absorb result stalls; then req_tready drops.
// Reset is synchronous and clears scanner state, queue and output; first_line resets to 1.
// csr_ready is always high; a write before any byte of the current source reloads the line.
`include "assert_macros.svh"

module source_tokenizer_top #(
   parameter int unsigned MAX_SOURCE_BYTES = 65536,
   parameter int unsigned QUEUE_DEPTH      = 4
) (
   input  logic        clock,
   input  logic        reset,
   // source bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,   // source_end
   // tokens
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // lexeme_start, lexeme_length, line_number
   output logic [3:0]  rsp_tuser,   // token_kind
   output logic        rsp_tlast,   // run_last
   // first_line register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // first_line
);

   logic                take;
   logic                q_push;
   logic                q_pop;
   logic                q_full;
   logic                q_valid;
   stz_pkg::bundle_type q_wdata;
   stz_pkg::bundle_type q_rdata;
   stz_pkg::mode_type   front_mode;
   logic                halted_take;
   logic                end_take;

   // accept a byte whenever the queue has room for its bundle
   assign req_tready = !q_full;
   assign take = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // scanner: classify the byte, advance the mode, collect finished tokens
   stz_front #(
      .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .text_byte  (req_tdata),
      .source_end (req_tlast),
      .cfg_we     (csr_valid && csr_ready),
      .cfg_data   (csr_data),
      .push       (q_push),
      .bundle     (q_wdata),
      .mode       (front_mode)
   );

   // hold token bundles so either side can stall on its own
   stz_queue #(
      .WIDTH($bits(stz_pkg::bundle_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wdata     (q_wdata),
      .pop       (q_pop),
      .rdata     (q_rdata),
      .full      (q_full),
      .not_empty (q_valid)
   );

   // serializer: drain one token per cycle from the head bundle while rsp_tready is high
   stz_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_rdata),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a byte taken while halted that does not end the source, and a source end taken
   assign halted_take = take && !req_tlast && (front_mode == stz_pkg::MODE_HALT);
   assign end_take = take && req_tlast;

   `STZ_ASSERT_NEVER(a_push_when_full, q_push && q_full, "bundle pushed into a full queue")
   `STZ_ASSERT(a_push_nonempty, q_push |-> (q_wdata.count != 2'd0), "empty bundle queued")
   `STZ_ASSERT(a_halt_quiet, halted_take |-> !q_push, "token from halted scanner")
   `STZ_ASSERT(a_end_restarts, end_take |=> (front_mode == stz_pkg::MODE_IDLE), "not idle")

endmodule

// File: dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SOURCE_LIMIT  = 65536;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned SETTLE_CYCLES = 16;

   // One request word: a source byte and its end-of-source mark
   typedef struct {
      logic [7:0] value;
      logic       last;
   } text_word_type;

   // One token as it should leave the result port
   typedef struct {
      stz_pkg::kind_type kind;
      logic [15:0]       start;
      logic [15:0]       length;
      logic [15:0]       line;
      logic              last;
   } due_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // text_byte
   logic        req_tlast = 1'b0;    // source_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;           // lexeme_start, lexeme_length, line_number
   logic [3:0]  rsp_tuser;           // token_kind
   logic        rsp_tlast;           // run_last
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = 16'h0000; // first_line

   source_tokenizer_top #(
      .MAX_SOURCE_BYTES(SOURCE_LIMIT),
      .QUEUE_DEPTH(4)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Source bytes waiting for the driver, and tokens still owed by the block
   text_word_type text_backlog[$];
   due_type       tokens_due[$];
   logic [7:0]    draft[$];

   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;
   logic        req_fire = 1'b0;
   logic        hold_req = 1'b0;
   int unsigned hold_left = 0;

   int unsigned failures = 0;
   int unsigned bytes_taken = 0;
   int unsigned sources_sent = 0;
   int unsigned tokens_checked = 0;
   int unsigned stall_cycles = 0;
   logic [13:0] kinds_seen = '0;

   // ---------------------------------------------------------------------
   // Scanner mirror: its own copy of the register and the scan state
   // ---------------------------------------------------------------------
   logic [15:0]       first_line;
   logic [15:0]       line_count;
   stz_pkg::mode_type scan_mode;
   int unsigned       byte_pos;
   int unsigned       token_start;
   int unsigned       word_len;
   logic [1:0]        kw_match;   // bit 0: still "var", bit 1: still "fun"
   due_type           step_tokens[$];

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic void restart_source();
      scan_mode   = stz_pkg::MODE_IDLE;
      byte_pos    = 0;
      token_start = 0;
      line_count  = first_line;
      word_len    = 0;
      kw_match    = 2'b11;
   endfunction

   // Record one token for the current byte; the block keeps at most three.
   function automatic void emit_token(stz_pkg::kind_type k, int unsigned s, int unsigned len);
      due_type t;
      if (step_tokens.size() >= stz_pkg::TOKENS_MAX) return;
      t.kind   = k;
      t.start  = s[15:0];
      t.length = len[15:0];
      t.line   = line_count;
      t.last   = 1'b0;
      step_tokens.insert(step_tokens.size(), t);
   endfunction

   // Close whatever token is open in front of the current byte.
   function automatic void close_open_token();
      int unsigned len;
      len = byte_pos - token_start;
      case (scan_mode)
         stz_pkg::MODE_WORD: begin
            if (word_len == 3 && kw_match[0]) emit_token(stz_pkg::KIND_VAR, token_start, 0);
            else if (word_len == 3 && kw_match[1]) emit_token(stz_pkg::KIND_FUN, token_start, 0);
            else emit_token(stz_pkg::KIND_IDENT, token_start, len);
         end
         stz_pkg::MODE_INT: emit_token(stz_pkg::KIND_INT, token_start, len);
         stz_pkg::MODE_DEC: emit_token(stz_pkg::KIND_DEC, token_start, len);
         stz_pkg::MODE_EQ:  emit_token(stz_pkg::KIND_EQ, token_start, 0);
         stz_pkg::MODE_STR: emit_token(stz_pkg::KIND_ERROR, token_start, 0);
         default: ;
      endcase
      if (scan_mode != stz_pkg::MODE_HALT) scan_mode = stz_pkg::MODE_IDLE;
   endfunction

   function automatic void consume_byte(logic [7:0] c);
      int unsigned p;
      p = byte_pos;
      case (scan_mode)
         stz_pkg::MODE_WORD: begin
            if (is_letter(c) || is_digit(c)) begin
               if (word_len < 3) begin
                  if (c != stz_pkg::KW_VAR[23 - 8*word_len -: 8]) kw_match[0] = 1'b0;
                  if (c != stz_pkg::KW_FUN[23 - 8*word_len -: 8]) kw_match[1] = 1'b0;
               end
               if (word_len < 7) word_len++;
               return;
            end
            close_open_token();
         end
         stz_pkg::MODE_INT: begin
            if (is_digit(c)) return;
            if (c == stz_pkg::CH_DOT) begin
               scan_mode = stz_pkg::MODE_DEC;
               return;
            end
            close_open_token();
         end
         stz_pkg::MODE_DEC: begin
            if (is_digit(c)) return;
            close_open_token();
         end
         stz_pkg::MODE_EQ: begin
            if (c == stz_pkg::CH_EQUAL) begin
               emit_token(stz_pkg::KIND_EQEQ, token_start, 0);
               scan_mode = stz_pkg::MODE_IDLE;
               return;
            end
            close_open_token();
         end
         stz_pkg::MODE_STR: begin
            if (c == stz_pkg::CH_QUOTE) begin
               emit_token(stz_pkg::KIND_STRING, token_start, p - token_start);
               scan_mode = stz_pkg::MODE_IDLE;
            end
            return;
         end
         default: ;
      endcase

      // The byte starts afresh from idle
      case (c)
         stz_pkg::CH_NL: begin
            line_count = line_count + 16'd1;
            return;
         end
         stz_pkg::CH_SPACE, stz_pkg::CH_TAB, stz_pkg::CH_CR, stz_pkg::CH_VT,
         stz_pkg::CH_FF: return;
         stz_pkg::CH_PLUS: begin
            emit_token(stz_pkg::KIND_PLUS, p, 0);
            return;
         end
         stz_pkg::CH_MINUS: begin
            emit_token(stz_pkg::KIND_MINUS, p, 0);
            return;
         end
         stz_pkg::CH_COLON: begin
            emit_token(stz_pkg::KIND_COLON, p, 0);
            return;
         end
         stz_pkg::CH_LPAREN: begin
            emit_token(stz_pkg::KIND_LPAREN, p, 0);
            return;
         end
         stz_pkg::CH_RPAREN: begin
            emit_token(stz_pkg::KIND_RPAREN, p, 0);
            return;
         end
         stz_pkg::CH_EQUAL: begin
            scan_mode   = stz_pkg::MODE_EQ;
            token_start = p;
            return;
         end
         stz_pkg::CH_QUOTE: begin
            scan_mode   = stz_pkg::MODE_STR;
            token_start = p + 1;
            return;
         end
         default: ;
      endcase
      if (is_digit(c)) begin
         scan_mode   = stz_pkg::MODE_INT;
         token_start = p;
      end else if (is_letter(c)) begin
         scan_mode   = stz_pkg::MODE_WORD;
         token_start = p;
         word_len    = 1;
         kw_match    = (c == "v") ? 2'b01 : (c == "f") ? 2'b10 : 2'b00;
      end else begin
         emit_token(stz_pkg::KIND_ERROR, p, 1);
         scan_mode = stz_pkg::MODE_HALT;
      end
   endfunction

   // Work out the tokens one accepted byte owes and queue them in order.
   function automatic void scan_text_byte(logic [7:0] c, logic last);
      due_type t;
      step_tokens.delete();
      if (scan_mode != stz_pkg::MODE_HALT) begin
         if (byte_pos >= SOURCE_LIMIT) begin
            emit_token(stz_pkg::KIND_ERROR, byte_pos, 0);
            scan_mode = stz_pkg::MODE_HALT;
         end else begin
            consume_byte(c);
            byte_pos++;
         end
      end
      if (last) begin
         close_open_token();
         restart_source();
      end
      for (int i = 0; i < step_tokens.size(); i++) begin
         t      = step_tokens[i];
         t.last = (i == step_tokens.size() - 1);
         tokens_due.insert(tokens_due.size(), t);
      end
   endfunction

   function automatic void apply_first_line(logic [15:0] v);
      first_line = v;
      if (byte_pos == 0 && scan_mode == stz_pkg::MODE_IDLE) line_count = v;
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("tb: token %s expected %0d got %0d", name, want, got);
         failures++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: offer the next byte at the falling edge once the last word went
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (text_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_tdata  <= text_backlog[0].value;
            req_tlast  <= text_backlog[0].last;
            req_tvalid <= 1'b1;
            void'(text_backlog.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else if (hold_req) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Monitor: predict on every accepted byte, check every accepted token
   always @(posedge clock) begin
      due_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            scan_text_byte(req_tdata, req_tlast);
            bytes_taken++;
         end
         if (req_tvalid && !req_tready) stall_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            if (tokens_due.size() == 0) begin
               $error("tb: token kind %0d arrived with nothing expected", rsp_tuser);
               failures++;
            end else begin
               want = tokens_due.pop_front();
               compare_field("kind", want.kind, rsp_tuser);
               compare_field("start", want.start, rsp_tdata[15:0]);
               compare_field("length", want.length, rsp_tdata[31:16]);
               compare_field("line", want.line, rsp_tdata[47:32]);
               compare_field("last", want.last, rsp_tlast);
               kinds_seen[want.kind] = 1'b1;
               tokens_checked++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic void queue_byte(logic [7:0] c, logic last);
      text_word_type w;
      w.value = c;
      w.last  = last;
      text_backlog.insert(text_backlog.size(), w);
      if (last) sources_sent++;
   endfunction

   // Queue a literal chunk; mark its final byte as the end of the source if asked.
   function automatic void queue_text(string s, bit ends_source);
      for (int i = 0; i < s.len(); i++)
         queue_byte(s[i], ends_source && i == s.len() - 1);
   endfunction

   function automatic void draft_byte(logic [7:0] c);
      draft.insert(draft.size(), c);
   endfunction

   function automatic void draft_text(string s);
      for (int i = 0; i < s.len(); i++) draft_byte(s[i]);
   endfunction

   function automatic logic [7:0] rand_letter();
      return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'("0" + $urandom_range(9));
   endfunction

   function automatic logic [7:0] rand_alnum();
      return $urandom_range(2) == 0 ? rand_digit() : rand_letter();
   endfunction

   // Build one mostly well-formed source of random lexemes and queue it;
   // return how many bytes it holds.
   function automatic int unsigned queue_random_source(int unsigned lexemes);
      int unsigned n;
      logic [7:0]  c;
      draft.delete();
      for (int i = 0; i < lexemes; i++) begin
         case ($urandom_range(11))
            0, 1: begin
               case ($urandom_range(6))
                  0: draft_byte(stz_pkg::CH_PLUS);
                  1: draft_byte(stz_pkg::CH_MINUS);
                  2: draft_byte(stz_pkg::CH_COLON);
                  3: draft_byte(stz_pkg::CH_LPAREN);
                  4: draft_byte(stz_pkg::CH_RPAREN);
                  5: draft_byte(stz_pkg::CH_EQUAL);
                  default: draft_text("==");
               endcase
            end
            2: begin
               // keywords, their prefixes, longer words that start with them and miscased forms
               case ($urandom_range(4))
                  0: draft_text("var");
                  1: draft_text("fun");
                  2: begin
                     if ($urandom_range(1)) draft_text("va");
                     else draft_text("f");
                  end
                  3: begin
                     draft_text($urandom_range(1) ? "var" : "fun");
                     draft_byte(rand_alnum());
                  end
                  default: draft_text($urandom_range(1) ? "Var" : "fUn");
               endcase
            end
            3, 4: begin
               draft_byte(rand_letter());
               n = $urandom_range(9);
               repeat (n) draft_byte(rand_alnum());
            end
            5, 6: begin
               n = $urandom_range(1, 5);
               repeat (n) draft_byte(rand_digit());
            end
            7: begin
               n = $urandom_range(1, 3);
               repeat (n) draft_byte(rand_digit());
               draft_byte(stz_pkg::CH_DOT);
               n = $urandom_range(3);
               repeat (n) draft_byte(rand_digit());
               // a second dot ends the decimal and halts the source
               if ($urandom_range(5) == 0) draft_byte(stz_pkg::CH_DOT);
            end
            8, 9: begin
               draft_byte(stz_pkg::CH_QUOTE);
               n = $urandom_range(6);
               repeat (n) begin
                  c = 8'($urandom_range(32, 126));
                  draft_byte(c == stz_pkg::CH_QUOTE ? stz_pkg::CH_NL : c);
               end
               if ($urandom_range(6) != 0) draft_byte(stz_pkg::CH_QUOTE);
            end
            10: draft_byte(8'($urandom_range(255)));
            default: begin
               n = $urandom_range(1, 2);
               repeat (n) draft_byte(stz_pkg::CH_NL);
            end
         endcase
         // separator; none at all makes lexemes end each other
         case ($urandom_range(9))
            4, 5: draft_byte(stz_pkg::CH_SPACE);
            6: draft_byte(stz_pkg::CH_NL);
            7: draft_byte(stz_pkg::CH_TAB);
            8: draft_byte(stz_pkg::CH_CR);
            9: draft_byte($urandom_range(1) ? stz_pkg::CH_VT : stz_pkg::CH_FF);
            default: ;
         endcase
      end
      if (draft.size() == 0) draft_byte(stz_pkg::CH_SPACE);
      for (int i = 0; i < draft.size(); i++)
         queue_byte(draft[i], i == draft.size() - 1);
      return draft.size();
   endfunction

   function automatic void queue_random_sources(int unsigned target);
      int unsigned queued;
      queued = 0;
      while (queued < target) queued += queue_random_source($urandom_range(2, 8));
   endfunction

   // Wait until every byte is in and every token is out, then let the block settle.
   task automatic wait_drained();
      while (text_backlog.size() != 0 || req_tvalid) @(posedge clock);
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_first_line(logic [15:0] v);
      @(negedge clock);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      apply_first_line(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      first_line = 16'd1;
      restart_source();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase 1: sender idles often, receiver idles more
      tx_idle_pct = 37;
      rx_idle_pct = 67;

      // Directed: every kind, keywords, a newline inside a string, a word ended
      // by a paren, a pending '=' flushed at the end, an open string at the end,
      // a second dot in a number, and stray bytes at both extremes
      queue_text("var\nfun==x(\"a\n\"):+-=", 1);
      queue_text("9\"q", 1);
      queue_text("1..", 0);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h00, 1'b1);
      wait_drained();

      write_first_line(16'h0000);
      queue_random_sources(30);
      wait_drained();

      // Phase 2: the other way round; line numbers wrap from the top
      tx_idle_pct = 67;
      rx_idle_pct = 37;
      write_first_line(16'hFFFF);
      queue_random_sources(25);
      wait_drained();

      // Phase 3: no idling; hold the result port long enough to back up the input
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_first_line(16'($urandom_range(65535)));
      @(posedge clock);
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      queue_random_sources(25);
      wait_drained();

      $display("tb: %0d bytes in %0d sources, %0d tokens checked, kinds seen %b",
               bytes_taken, sources_sent, tokens_checked, kinds_seen);
      $display("tb: input held off for %0d cycles by result back-pressure", stall_cycles);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
